// File: sv/drb_pkg.sv
package drb_pkg;

  localparam int unsigned MaxRangesDef      = 4096;
  localparam int unsigned MaxQueryBlocksDef = 512;
  localparam int unsigned BitsPerByte       = 8;
  localparam int unsigned WordBits          = 64;

  localparam logic [32:0] BlockCountRst     = 33'd262144;
  localparam logic [15:0] BlocksPerRangeRst = 16'd64;

  typedef enum logic [1:0] {
    REQ_MARK_CHANGED = 2'd0,
    REQ_MARK_CLEAN   = 2'd1,
    REQ_QUERY        = 2'd2,
    REQ_UNUSED       = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_ORDER    = 2'd2
  } status_t;

  typedef enum logic {
    CFG_BLOCK_COUNT      = 1'b0,
    CFG_BLOCKS_PER_RANGE = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_MDIV0,
    S_MDIV1,
    S_MRD,
    S_MWR,
    S_ACK,
    S_ERR,
    S_QDIV0,
    S_QDIV1,
    S_QRD,
    S_QBIT,
    S_QEMIT
  } state_t;

endpackage

// File: sv/drb_if.sv
interface drb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] start_block;
  logic [31:0] end_block;

  modport source (output valid, req_type, start_block, end_block, input ready);
  modport sink   (input valid, req_type, start_block, end_block, output ready);
endinterface

interface drb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] changed_bits;
  logic [5:0] byte_index;
  logic [1:0] status;
  logic       last;

  modport source (output valid, changed_bits, byte_index, status, last, input ready);
  modport sink   (input valid, changed_bits, byte_index, status, last, output ready);
endinterface

// File: sv/drb_div.sv
module drb_div import drb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [32:0] quotient,
  output logic [15:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[32]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      quo_nxt  = dividend;
      rem_nxt  = 16'd0;
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      quo_nxt = {quo_r[31:0], ge};
      rem_nxt = ge ? diff[15:0] : trial[15:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: sv/dirty_range_bitmap.sv
// Changed-range tracker: one bit per range of blocks_per_range blocks, kept in a
// single-port-style word memory of MAX_RANGES/64 64-bit words with a registered
// read. After reset the block sweeps the memory to all ones, one word per cycle,
// and takes no request until the sweep ends; configuration writes are taken at
// any time. Every range index comes from a shared serial divider. A mark request
// runs up to two divisions, then a memory read and a write per touched memory
// word, then one acknowledgement. A query runs two divisions, then a memory read
// and a bit select per block covered, and one emit step per result byte. Error
// results and acks each load a single result. Results leave through an output
// register, so a stalled consumer only holds the request that is currently
// producing a result.
module dirty_range_bitmap import drb_pkg::*; #(
  parameter int unsigned MAX_RANGES       = MaxRangesDef,
  parameter int unsigned MAX_QUERY_BLOCKS = MaxQueryBlocksDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [32:0] cfg_wdata,
  drb_req_if.sink     in_req,
  drb_res_if.source   out_res
);

  localparam int unsigned Depth = (MAX_RANGES + WordBits - 1) / WordBits;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned QW    = $clog2(MAX_QUERY_BLOCKS);
  localparam int unsigned OW    = (QW < 4) ? 4 : QW;

  state_t state_r, state_nxt;

  logic [32:0] bc_r;
  logic [15:0] bpr_r;
  logic [15:0] bpr_eff;

  logic [1:0]  type_r, type_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] end_r, end_nxt;
  logic [32:0] lo_r, lo_nxt;
  logic [32:0] hi_r, hi_nxt;
  logic [AW-1:0] w_r, w_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [32:0] rng_r, rng_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [32:0] full_r, full_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [OW-1:0] qlm1_r, qlm1_nxt;
  logic [7:0]  byte_r, byte_nxt;

  logic        div_start;
  logic [32:0] div_a;
  logic        div_done;
  logic [32:0] div_q;
  logic [15:0] div_rem;

  logic [WordBits-1:0] mem [Depth];
  logic [WordBits-1:0] rdata_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [WordBits-1:0] mem_wdata;

  logic        out_valid_r;
  logic [7:0]  out_bits_r, ld_bits;
  logic [5:0]  out_idx_r, ld_idx;
  logic [1:0]  out_st_r, ld_st;
  logic        out_last_r, ld_last;
  logic        out_ld, out_free;

  logic        in_acc;
  logic [32:0] bc_m1, endc;
  logic        clean_req, mk_empty, q_order, q_long;
  logic        mk_skip;
  logic [32:0] hi_v;
  logic [AW-1:0] lo_w, hi_w;
  logic [5:0]  lb, hb;
  logic [WordBits-1:0] mask;
  logic        ch, q_last, in_span;

  assign bpr_eff   = (bpr_r == 16'd0) ? 16'd1 : bpr_r;
  assign out_free  = !out_valid_r || out_res.ready;
  assign in_acc    = in_req.valid && in_req.ready;
  assign clean_req = type_r == REQ_MARK_CLEAN;
  assign bc_m1     = bc_r - 33'd1;
  assign endc      = ({1'b0, end_r} > bc_m1) ? bc_m1 : {1'b0, end_r};
  assign mk_empty  = (bc_r == 33'd0) || ({1'b0, start_r} > endc);
  assign q_order   = end_r < start_r;
  assign q_long    = (end_r - start_r) >= 32'(MAX_QUERY_BLOCKS);
  assign mk_skip   = (clean_req && (div_q <= lo_r)) || (lo_r >= 33'(MAX_RANGES));
  assign hi_v      = clean_req ? div_q - 33'd1 : div_q;
  assign lo_w      = lo_r[AW+5:6];
  assign hi_w      = hi_r[AW+5:6];
  assign lb        = (w_r == lo_w) ? lo_r[5:0] : 6'd0;
  assign hb        = (w_r == hi_w) ? hi_r[5:0] : 6'd63;
  assign mask      = ({WordBits{1'b1}} << lb) & ({WordBits{1'b1}} >> (6'd63 - hb));
  assign in_span   = off_r <= qlm1_r;
  assign ch        = !in_span || (rng_r >= full_r) || (rng_r >= 33'(MAX_RANGES)) ||
                     rdata_r[rng_r[5:0]];
  assign q_last    = off_r[OW-1:3] == qlm1_r[OW-1:3];

  drb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (bpr_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(Depth - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_req.req_type != REQ_UNUSED) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (type_r == REQ_QUERY) begin
          state_nxt = (q_order || q_long) ? S_ERR : S_QDIV0;
        end else begin
          state_nxt = mk_empty ? S_ACK : S_MDIV0;
        end
      end
      S_MDIV0: if (div_done) state_nxt = S_MDIV1;
      S_MDIV1: if (div_done) state_nxt = mk_skip ? S_ACK : S_MRD;
      S_MRD:   state_nxt = S_MWR;
      S_MWR:   state_nxt = (w_r == hi_w) ? S_ACK : S_MRD;
      S_ACK:   if (out_free) state_nxt = S_IDLE;
      S_ERR:   if (out_free) state_nxt = S_IDLE;
      S_QDIV0: if (div_done) state_nxt = S_QDIV1;
      S_QDIV1: if (div_done) state_nxt = S_QRD;
      S_QRD:   state_nxt = S_QBIT;
      S_QBIT:  state_nxt = (off_r[2:0] == 3'b111) ? S_QEMIT : S_QRD;
      S_QEMIT: if (out_free) state_nxt = q_last ? S_IDLE : S_QRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    type_nxt  = type_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    w_nxt     = w_r;
    clr_nxt   = clr_r;
    rng_nxt   = rng_r;
    rem_nxt   = rem_r;
    full_nxt  = full_r;
    off_nxt   = off_r;
    qlm1_nxt  = qlm1_r;
    byte_nxt  = byte_r;
    div_start = 1'b0;
    div_a     = 33'd0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = w_r;
    mem_raddr = w_r;
    mem_wdata = rdata_r;
    out_ld    = 1'b0;
    ld_bits   = 8'd0;
    ld_idx    = 6'd0;
    ld_st     = ST_OK;
    ld_last   = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {WordBits{1'b1}};
        clr_nxt   = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          type_nxt  = in_req.req_type;
          start_nxt = in_req.start_block;
          end_nxt   = in_req.end_block;
        end
      end
      S_CHK: begin
        qlm1_nxt = OW'(end_r - start_r);
        if (type_r == REQ_QUERY) begin
          div_start = !(q_order || q_long);
          div_a     = {1'b0, start_r};
        end else begin
          div_start = !mk_empty;
          div_a     = clean_req ? {1'b0, start_r} + {17'd0, bpr_eff} - 33'd1
                                : {1'b0, start_r};
        end
      end
      S_MDIV0: begin
        if (div_done) begin
          lo_nxt    = div_q;
          div_start = 1'b1;
          div_a     = clean_req ? endc + 33'd1 : endc;
        end
      end
      S_MDIV1: begin
        if (div_done) begin
          hi_nxt = (hi_v >= 33'(MAX_RANGES)) ? 33'(MAX_RANGES - 1) : hi_v;
          w_nxt  = lo_w;
        end
      end
      S_MRD: mem_re = 1'b1;
      S_MWR: begin
        mem_we    = 1'b1;
        mem_wdata = clean_req ? (rdata_r & ~mask) : (rdata_r | mask);
        w_nxt     = w_r + AW'(1);
      end
      S_ACK: out_ld = out_free;
      S_ERR: begin
        out_ld = out_free;
        ld_st  = q_order ? ST_ORDER : ST_TOO_LONG;
      end
      S_QDIV0: begin
        if (div_done) begin
          rng_nxt   = div_q;
          rem_nxt   = div_rem;
          div_start = 1'b1;
          div_a     = bc_r;
        end
      end
      S_QDIV1: begin
        if (div_done) begin
          full_nxt = div_q;
          off_nxt  = '0;
        end
      end
      S_QRD: begin
        mem_re    = 1'b1;
        mem_raddr = rng_r[AW+5:6];
      end
      S_QBIT: begin
        byte_nxt[off_r[2:0]] = ch;
        if (rem_r == bpr_eff - 16'd1) begin
          rem_nxt = 16'd0;
          rng_nxt = rng_r + 33'd1;
        end else begin
          rem_nxt = rem_r + 16'd1;
        end
        if (off_r[2:0] != 3'b111) off_nxt = off_r + OW'(1);
      end
      S_QEMIT: begin
        out_ld  = out_free;
        ld_bits = byte_r;
        ld_idx  = 6'(off_r >> 3);
        ld_last = q_last;
        if (out_free) off_nxt = off_r + OW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      bc_r        <= BlockCountRst;
      bpr_r       <= BlocksPerRangeRst;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BLOCK_COUNT:      bc_r  <= cfg_wdata;
          CFG_BLOCKS_PER_RANGE: bpr_r <= cfg_wdata[15:0];
        endcase
      end
    end
    type_r  <= type_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    w_r     <= w_nxt;
    rng_r   <= rng_nxt;
    rem_r   <= rem_nxt;
    full_r  <= full_nxt;
    off_r   <= off_nxt;
    qlm1_r  <= qlm1_nxt;
    byte_r  <= byte_nxt;
    if (out_ld) begin
      out_bits_r <= ld_bits;
      out_idx_r  <= ld_idx;
      out_st_r   <= ld_st;
      out_last_r <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  assign in_req.ready         = state_r == S_IDLE;
  assign out_res.valid        = out_valid_r;
  assign out_res.changed_bits = out_bits_r;
  assign out_res.byte_index   = out_idx_r;
  assign out_res.status       = out_st_r;
  assign out_res.last         = out_last_r;

  a_div_idle_chk: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !(state_r == S_MRD || state_r == S_MWR || state_r == S_QRD ||
                    state_r == S_QBIT || state_r == S_QEMIT))
    else $error("divider started outside a divide step");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> out_free)
    else $error("result register overwritten while occupied");

  a_mark_write_mask: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MWR |-> mask != '0)
    else $error("empty mask on bitmap update");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CHK || state_r == S_IDLE))
    else $error("request accepted outside idle");

endmodule
